[design/tqsp_pkg.sv]
package tqsp_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Protocol numbers.
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] PPP_IPV4 = 16'h0021;
    localparam logic [15:0] PPP_IPV6 = 16'h0057;

    // Item function codes.
    typedef enum logic {
        FUNC_SEND = 1'b0,
        FUNC_DONE = 1'b1
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LINK_DOWN = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_TAG    = 3'd3,
        ST_BAD_PROTO = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_LINK_UP     = 1'b0,
        REG_QUEUE_COUNT = 1'b1
    } reg_idx_t;

    // One packet descriptor as held in a queue.
    typedef struct packed {
        logic        v6;
        logic [15:0] bytes;
        logic [15:0] id;
    } entry_t;

    // Queue status seen by the scheduler.
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

[design/tqsp_fifo.sv]
module tqsp_fifo
    import tqsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  entry_t     wdata,
    input  logic       pop,
    output entry_t     head,
    output fifo_stat_t stat
);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Status from the fill count.
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // An empty queue that is pushed and popped in the same cycle passes the new item through.
    assign head = stat.empty ? wdata : mem[rd_ptr_reg];

    // Pointer advance with wrap at the queue depth.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
    end

    // Fill count follows pushes and pops.
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Descriptor storage, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[design/two_queue_strict_priority_tx_top.sv]
// A result is loaded into the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless out_stall holds a result; the queue update and
// the start decision settle in the accepting cycle, and the single output register sets the rate.
// Reset: rst_n is asynchronous and active low; it empties both queues, marks the
// transmitter ready, sets link_up to 1 and queue_count to 2, and drops out_valid.
module two_queue_strict_priority_tx_top
    import tqsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic        tag_valid,
    input  logic        queue_index,
    input  logic [15:0] packet_id,
    input  logic [15:0] packet_bytes,
    input  logic [15:0] ether_type,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [2:0]  status,
    output logic        start_tx,
    output logic [15:0] tx_packet_id,
    output logic [15:0] tx_bytes,
    output logic [15:0] tx_protocol,
    output logic        busy_res,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        link_up_reg;
    logic [1:0]  queue_count_reg;
    logic        busy_reg;
    logic        busy_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accepted_reg;
    status_t     status_reg;
    logic        start_reg;
    entry_t      tx_entry_reg;

    logic        in_accept;
    logic        is_send;
    logic        is_done;
    logic        target;
    logic        v6;
    status_t     send_status;
    logic        send_ok;
    logic        push_hi;
    logic        push_lo;
    logic        can_start;
    logic        pop_hi;
    logic        pop_lo;
    entry_t      new_entry;
    entry_t      hi_head;
    entry_t      lo_head;
    entry_t      start_entry;
    fifo_stat_t  hi_stat;
    fifo_stat_t  lo_stat;
    reg_idx_t    reg_idx;

    // Handshake: the output register frees the input side unless a result is held.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign is_send   = in_accept & (func_t'(func) == FUNC_SEND);
    assign is_done   = in_accept & (func_t'(func) == FUNC_DONE);

    // Queue choice: the tag is used only when both queues are in service.
    assign target = queue_count_reg[1] ? queue_index : 1'b0;
    assign v6     = (ether_type == ETH_IPV6);

    // Send checks in priority order.
    always_comb
    begin
        if (!link_up_reg)
        begin
            send_status = ST_LINK_DOWN;
        end
        else if (queue_count_reg[1] && !tag_valid)
        begin
            send_status = ST_NO_TAG;
        end
        else if (ether_type != ETH_IPV4 && ether_type != ETH_IPV6)
        begin
            send_status = ST_BAD_PROTO;
        end
        else if (target ? lo_stat.full : hi_stat.full)
        begin
            send_status = ST_FULL;
        end
        else
        begin
            send_status = ST_OK;
        end
    end

    assign send_ok   = is_send & (send_status == ST_OK);
    assign push_hi   = send_ok & ~target;
    assign push_lo   = send_ok & target;
    assign new_entry = '{v6: v6, bytes: packet_bytes, id: packet_id};

    // Start decision: a done item frees a busy transmitter, a queued send finds it ready.
    assign can_start = (is_done & busy_reg) | (send_ok & ~busy_reg);
    assign pop_hi    = can_start & (~hi_stat.empty | push_hi);
    assign pop_lo    = can_start & ~pop_hi & (~lo_stat.empty | push_lo);
    assign start_entry = pop_hi ? hi_head : lo_head;

    always_comb
    begin
        busy_next = busy_reg;
        if (can_start)
        begin
            busy_next = pop_hi | pop_lo;
        end
    end

    tqsp_fifo u_hi_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_hi),
        .wdata (new_entry),
        .pop   (pop_hi),
        .head  (hi_head),
        .stat  (hi_stat)
    );

    tqsp_fifo u_lo_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_lo),
        .wdata (new_entry),
        .pop   (pop_lo),
        .head  (lo_head),
        .stat  (lo_stat)
    );

    // Output register control.
    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            accepted_reg <= send_ok;
            status_reg   <= is_send ? send_status : ST_OK;
            start_reg    <= pop_hi | pop_lo;
            tx_entry_reg <= (pop_hi | pop_lo) ? start_entry : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign status       = status_reg;
    assign start_tx     = start_reg;
    assign tx_packet_id = tx_entry_reg.id;
    assign tx_bytes     = tx_entry_reg.bytes;
    assign tx_protocol  = !start_reg ? 16'h0000 : (tx_entry_reg.v6 ? PPP_IPV6 : PPP_IPV4);
    assign busy_res     = busy_reg;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg     <= 1'b1;
            queue_count_reg <= 2'd2;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_LINK_UP:     link_up_reg     <= pwdata[0];
                REG_QUEUE_COUNT: queue_count_reg <= pwdata[1:0];
                default:         link_up_reg     <= link_up_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LINK_UP:     prdata = {31'd0, link_up_reg};
            REG_QUEUE_COUNT: prdata = {30'd0, queue_count_reg};
            default:         prdata = '0;
        endcase
    end

    // Only one queue is popped per item.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop_hi && pop_lo))
        else $error("both queues popped in one cycle");

    // The transmitter becomes busy only when a head is started.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(pop_hi || pop_lo))
        else $error("transmitter went busy without a start");

    // A started packet always leaves the transmitter busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pop_hi || pop_lo)) |=> (busy_reg && start_tx))
        else $error("start did not mark the transmitter busy");

    // A queued send always reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (status_reg == ST_OK))
        else $error("accepted item with an error status");

endmodule
